@@ design/vaa_pkg.sv @@
package vaa_pkg;

    localparam int CW = 16;
    localparam int FB = 16;
    localparam int AW = FB + 3;
    localparam int RW = FB + 1;
    localparam int PIPE_STAGES = 5;

    localparam int Q16_A1 = 1628;
    localparam int Q16_A0 = 12243;
    localparam int Q16_C1 = 6167;
    localparam int Q16_C0 = 21767;
    localparam int Q16_HALF_PI = 102944;
    localparam int Q16_PI = 205887;

    localparam int SCALE_UP = (FB >= 16) ? FB - 16 : 0;
    localparam int SCALE_DN = (FB < 16) ? 16 - FB : 0;

    typedef logic signed [AW-1:0] t_sval;
    typedef logic [RW-1:0] t_ratio;

    typedef struct packed {
        logic zero;
        logic swap;
        logic xneg;
        logic yneg;
    } t_meta;

    typedef struct packed {
        logic [CW-1:0] mx;
        logic [CW-1:0] rem;
        logic nb;
        t_ratio q;
        t_meta meta;
    } t_div;

    // Moves a Q.16 constant to the working fraction width, rounding half up when narrower.
    function automatic t_sval scale_q16(input int c);
        int v;
        if (SCALE_DN == 0) begin
            v = c << SCALE_UP;
        end else begin
            v = (c + (1 << (SCALE_DN - 1))) >> SCALE_DN;
        end
        return AW'(v);
    endfunction

    // Fixed-point product rounded toward minus infinity.
    function automatic t_sval fmul(input t_sval a, input t_sval b);
        logic signed [2*AW-1:0] p;
        p = a * b;
        return p[FB+AW-1:FB];
    endfunction

    localparam t_sval K_A1 = scale_q16(Q16_A1);
    localparam t_sval K_A0 = scale_q16(Q16_A0);
    localparam t_sval K_NC1 = -scale_q16(Q16_C1);
    localparam t_sval K_C0 = scale_q16(Q16_C0);
    localparam t_sval K_HALF_PI = scale_q16(Q16_HALF_PI);
    localparam t_sval K_PI = scale_q16(Q16_PI);

endpackage

@@ design/vaa_if.sv @@
interface vaa_vec_if;
    logic valid;
    logic ready;
    logic signed [vaa_pkg::CW-1:0] vec_x;
    logic signed [vaa_pkg::CW-1:0] vec_y;

    modport source (output valid, output vec_x, output vec_y, input ready);
    modport sink (input valid, input vec_x, input vec_y, output ready);
endinterface

interface vaa_angle_if;
    logic valid;
    logic ready;
    logic signed [vaa_pkg::AW-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink (input valid, input angle, output ready);
endinterface

@@ design/vaa_prep.sv @@
module vaa_prep (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic signed [vaa_pkg::CW-1:0] i_x,
    input  logic signed [vaa_pkg::CW-1:0] i_y,
    output logic o_valid,
    input  logic i_ready,
    output vaa_pkg::t_div o_div
);
    logic [vaa_pkg::CW-1:0] n_ax;
    logic [vaa_pkg::CW-1:0] n_ay;
    logic [vaa_pkg::CW-1:0] n_mn;
    vaa_pkg::t_div n_div;
    vaa_pkg::t_div r_div;
    logic r_v;

    always_comb begin
        n_ax = i_x[vaa_pkg::CW-1] ? (~i_x + 1'b1) : i_x;
        n_ay = i_y[vaa_pkg::CW-1] ? (~i_y + 1'b1) : i_y;
        n_div.meta.zero = (n_ax == '0) && (n_ay == '0);
        n_div.meta.swap = n_ay > n_ax;
        n_div.meta.xneg = i_x[vaa_pkg::CW-1];
        n_div.meta.yneg = i_y[vaa_pkg::CW-1];
        n_div.mx = n_div.meta.swap ? n_ay : n_ax;
        n_mn = n_div.meta.swap ? n_ax : n_ay;
        // The first division cell shifts the remainder back up, taking in the low bit.
        n_div.rem = {1'b0, n_mn[vaa_pkg::CW-1:1]};
        n_div.nb = n_mn[0];
        n_div.q = '0;
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_div = r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_div <= n_div;
        end
    end
endmodule

@@ design/vaa_div_cell.sv @@
module vaa_div_cell (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  vaa_pkg::t_div i_div,
    output logic o_valid,
    input  logic i_ready,
    output vaa_pkg::t_div o_div
);
    logic [vaa_pkg::CW:0] n_trial;
    logic [vaa_pkg::CW:0] n_diff;
    logic n_ge;
    vaa_pkg::t_div n_div;
    vaa_pkg::t_div r_div;
    logic r_v;

    always_comb begin
        n_trial = {i_div.rem, i_div.nb};
        n_diff = n_trial - {1'b0, i_div.mx};
        n_ge = n_trial >= {1'b0, i_div.mx};
        n_div = i_div;
        // The remainder stays below the divisor, so it always fits the component width.
        n_div.rem = n_ge ? n_diff[vaa_pkg::CW-1:0] : n_trial[vaa_pkg::CW-1:0];
        n_div.nb = 1'b0;
        n_div.q = {i_div.q[vaa_pkg::RW-2:0], n_ge};
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_div = r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_div <= n_div;
        end
    end
endmodule

@@ design/vaa_poly.sv @@
module vaa_poly (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  vaa_pkg::t_ratio i_r,
    input  vaa_pkg::t_meta i_meta,
    output logic o_valid,
    input  logic i_ready,
    output vaa_pkg::t_sval o_a,
    output vaa_pkg::t_meta o_meta
);
    localparam int NS = vaa_pkg::PIPE_STAGES;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_vin;
    logic [NS:0] w_rdy;
    vaa_pkg::t_meta r_meta [NS];

    vaa_pkg::t_sval n_r;
    vaa_pkg::t_sval r1_r, r1_r2;
    vaa_pkg::t_sval r2_r, r2_r2, r2_r3, r2_r4;
    vaa_pkg::t_sval r3_r, r3_r2, r3_r3, r3_a, r3_c;
    vaa_pkg::t_sval r4_r, r4_r3, r4_a;
    vaa_pkg::t_sval r5_a;

    assign n_r = vaa_pkg::t_sval'(i_r);

    // Each stage may load when it is empty or when the stage after it is loading.
    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end
    assign w_vin = {r_v[NS-2:0], i_valid};
    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_a = r5_a;
    assign o_meta = r_meta[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_meta[0] <= i_meta;
            r1_r <= n_r;
            r1_r2 <= vaa_pkg::fmul(n_r, n_r);
        end
        if (w_rdy[1]) begin
            r_meta[1] <= r_meta[0];
            r2_r <= r1_r;
            r2_r2 <= r1_r2;
            r2_r3 <= vaa_pkg::fmul(r1_r2, r1_r);
            r2_r4 <= vaa_pkg::fmul(r1_r2, r1_r2);
        end
        if (w_rdy[2]) begin
            r_meta[2] <= r_meta[1];
            r3_r <= r2_r;
            r3_r2 <= r2_r2;
            r3_r3 <= r2_r3;
            r3_a <= vaa_pkg::fmul(vaa_pkg::K_A1, r2_r4) + vaa_pkg::K_A0;
            r3_c <= vaa_pkg::fmul(vaa_pkg::K_NC1, r2_r4) - vaa_pkg::K_C0;
        end
        if (w_rdy[3]) begin
            r_meta[3] <= r_meta[2];
            r4_r <= r3_r;
            r4_r3 <= r3_r3;
            r4_a <= vaa_pkg::fmul(r3_a, r3_r2) + r3_c;
        end
        if (w_rdy[4]) begin
            r_meta[4] <= r_meta[3];
            r5_a <= vaa_pkg::fmul(r4_a, r4_r3) + r4_r;
        end
    end
endmodule

@@ design/vaa_fold.sv @@
module vaa_fold (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  vaa_pkg::t_sval i_a,
    input  vaa_pkg::t_meta i_meta,
    output logic o_valid,
    input  logic i_ready,
    output vaa_pkg::t_sval o_angle
);
    vaa_pkg::t_sval n_s1, n_s2, n_s3, n_angle;
    vaa_pkg::t_sval r_angle;
    logic r_v;

    // Reflect the first-octant angle out to the quadrant of the original vector.
    always_comb begin
        n_s1 = i_meta.swap ? vaa_pkg::K_HALF_PI - i_a : i_a;
        n_s2 = i_meta.xneg ? vaa_pkg::K_PI - n_s1 : n_s1;
        n_s3 = i_meta.yneg ? -n_s2 : n_s2;
        n_angle = i_meta.zero ? '0 : n_s3;
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_angle = r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_angle <= n_angle;
        end
    end
endmodule

@@ design/vector_angle_atan2_unit.sv @@
// Angle of a signed two-dimensional vector, in radians with 16 fraction bits.
//
// i_vec carries one vector (vec_x, vec_y) per item; o_res returns one angle per item,
// in the range -pi..+pi, in the same order. A zero vector gives an angle of zero.
// Both channels move an item on a clock edge where valid and ready are both high.
//
// From acceptance to o_res.valid an item passes a preparation register for magnitude
// and octant, 17 division cells that each resolve one bit of the ratio min/max, five
// multiplier stages for the arctangent polynomial and one register for the octant
// reflection. The block takes one item every cycle unless o_res.ready holds it back;
// the rate is set by the division cell chain, which moves items one cell per cycle.
//
// Every stage holds its own valid bit and moves forward whenever the stage after it
// is empty or moving, so bubbles close up. When the receiver holds o_res.ready low
// the results queue in the stages and i_vec.ready falls only once all 24 are full.
// Synchronous reset empties every stage; no result is pending after reset.
module vector_angle_atan2_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    vaa_vec_if.sink i_vec,
    vaa_angle_if.source o_res
);
    localparam int RW = vaa_pkg::RW;
    localparam vaa_pkg::t_ratio RATIO_ONE = vaa_pkg::t_ratio'(1) << vaa_pkg::FB;

    logic [RW:0] w_dv;
    logic [RW:0] w_dr;
    vaa_pkg::t_div w_div [RW+1];

    logic w_pv, w_pr;
    vaa_pkg::t_sval w_pa;
    vaa_pkg::t_meta w_pm;

    vaa_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vec.valid),
        .o_ready (i_vec.ready),
        .i_x     (i_vec.vec_x),
        .i_y     (i_vec.vec_y),
        .o_valid (w_dv[0]),
        .i_ready (w_dr[0]),
        .o_div   (w_div[0])
    );

    for (genvar k = 0; k < RW; k++) begin : g_div
        vaa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv[k]),
            .o_ready (w_dr[k]),
            .i_div   (w_div[k]),
            .o_valid (w_dv[k+1]),
            .i_ready (w_dr[k+1]),
            .o_div   (w_div[k+1])
        );
    end

    vaa_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dv[RW]),
        .o_ready (w_dr[RW]),
        .i_r     (w_div[RW].q),
        .i_meta  (w_div[RW].meta),
        .o_valid (w_pv),
        .i_ready (w_pr),
        .o_a     (w_pa),
        .o_meta  (w_pm)
    );

    vaa_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pv),
        .o_ready (w_pr),
        .i_a     (w_pa),
        .i_meta  (w_pm),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_angle (o_res.angle)
    );

    // For a nonzero vector the quotient never exceeds one, since the smaller magnitude
    // is the dividend.
    a_ratio_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dv[RW] && !w_div[RW].meta.zero) |-> (w_div[RW].q <= RATIO_ONE))
        else $error("ratio above one");

    // The division remainder stays below a nonzero divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dv[RW] && (w_div[RW].mx != '0)) |-> (w_div[RW].rem < w_div[RW].mx))
        else $error("division remainder out of range");

    // Results lie within -pi..+pi.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.angle <= vaa_pkg::K_PI) && (o_res.angle >= -vaa_pkg::K_PI)))
        else $error("angle out of range");

    // A zero vector leaves the polynomial stages flagged and is turned into a zero angle.
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pv && w_pr && w_pm.zero) |=> (o_res.angle == '0))
        else $error("zero vector gave a nonzero angle");
endmodule

@@ tb/angle_checker.sv @@
module angle_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    vaa_vec_if   i_vec,
    vaa_angle_if i_res,
    output int   o_fail_count,
    output int   o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 25;

    typedef struct {
        logic signed [vaa_pkg::CW-1:0] x;
        logic signed [vaa_pkg::CW-1:0] y;
        vaa_pkg::t_sval                angle;
    } t_angle_entry;

    t_angle_entry expected_angles[$];

    // Brings a Q.16 constant to the block's fraction width, rounding half up when narrower.
    function automatic longint fit_const(input longint c);
        if (vaa_pkg::FB >= 16) begin
            return c <<< (vaa_pkg::FB - 16);
        end
        return (c + (64'sd1 <<< (15 - vaa_pkg::FB))) >>> (16 - vaa_pkg::FB);
    endfunction

    // Product rounded toward minus infinity.
    function automatic longint floor_product(input longint a, input longint b);
        return (a * b) >>> vaa_pkg::FB;
    endfunction

    function automatic vaa_pkg::t_sval predict_angle(input logic signed [vaa_pkg::CW-1:0] x,
                                                     input logic signed [vaa_pkg::CW-1:0] y);
        longint sx, sy, ax, ay, mx, mn;
        longint r, r2, r3, r4, acc, corr;
        sx = x;
        sy = y;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        if (ax == 0 && ay == 0) begin
            return '0;
        end
        mx = (ay > ax) ? ay : ax;
        mn = (ay < ax) ? ay : ax;
        r = (mn <<< vaa_pkg::FB) / mx;
        r2 = floor_product(r, r);
        r3 = floor_product(r2, r);
        r4 = floor_product(r2, r2);
        acc = floor_product(fit_const(vaa_pkg::Q16_A1), r4) + fit_const(vaa_pkg::Q16_A0);
        corr = floor_product(-fit_const(vaa_pkg::Q16_C1), r4) - fit_const(vaa_pkg::Q16_C0);
        acc = floor_product(acc, r2) + corr;
        acc = floor_product(acc, r3) + r;
        // Fold the first-octant angle out to the octant of the vector.
        if (ay > ax) begin
            acc = fit_const(vaa_pkg::Q16_HALF_PI) - acc;
        end
        if (sx < 0) begin
            acc = fit_const(vaa_pkg::Q16_PI) - acc;
        end
        if (sy < 0) begin
            acc = -acc;
        end
        return vaa_pkg::t_sval'(acc);
    endfunction

    task automatic report_mismatch(input string what);
        if (o_fail_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_angle_entry head;
        if (!i_rst_n) begin
            expected_angles.delete();
        end else begin
            if (i_vec.valid && i_vec.ready) begin
                expected_angles.push_back('{x: i_vec.vec_x, y: i_vec.vec_y,
                                            angle: predict_angle(i_vec.vec_x, i_vec.vec_y)});
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_angles.size() == 0) begin
                    report_mismatch($sformatf("angle %0d with no item outstanding",
                                              i_res.angle));
                end else begin
                    head = expected_angles.pop_front();
                    if (i_res.angle !== head.angle) begin
                        report_mismatch($sformatf("vector (%0d,%0d) angle %0d, predicted %0d",
                                                  head.x, head.y, i_res.angle, head.angle));
                    end
                end
            end
        end
        o_pending_count = expected_angles.size();
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES = 40;

    typedef logic signed [vaa_pkg::CW-1:0] t_comp;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    int   items_sent;
    bit   steady_phase;
    bit   hold_off_done;

    vaa_vec_if   vec_ch ();
    vaa_angle_if res_ch ();

    vector_angle_atan2_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (vec_ch),
        .o_res   (res_ch)
    );

    angle_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vec           (vec_ch),
        .i_res           (res_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_comp edge_component();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    task automatic send_vector(input t_comp x, input t_comp y);
        int gap;
        vec_ch.valid <= 1'b1;
        vec_ch.vec_x <= x;
        vec_ch.vec_y <= y;
        do @(posedge i_clk); while (!vec_ch.ready);
        items_sent++;
        if (!steady_phase && $urandom_range(99) < 5) begin
            vec_ch.valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        t_comp dir_x[$];
        t_comp dir_y[$];
        t_comp rx, ry;
        int mag;
        dir_x = '{0, 32767, -32768, 0, 0, -32768, 32767, -1, 1, -1, 1, -1,
                  32767, -32768, 1, 32767, -32768, 1, 100, 200, -5, 0, 1, 0, 7};
        dir_y = '{0, 0, 0, 32767, -32768, -32768, 32767, 0, 1, -1, -1, 1,
                  -32768, 32767, 32767, 1, 1, -32768, 200, 100, 3, 1, 0, -1, -7};
        items_sent = 0;
        steady_phase = 1'b0;
        i_rst_n <= 1'b0;
        vec_ch.valid <= 1'b0;
        vec_ch.vec_x <= '0;
        vec_ch.vec_y <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Axes, diagonals, full-scale and most negative components.
        foreach (dir_x[i]) begin
            send_vector(dir_x[i], dir_y[i]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_phase = (n >= 350 && n < 550);
            case ($urandom_range(99)) inside
                [0:59]: begin
                    rx = t_comp'($urandom);
                    ry = t_comp'($urandom);
                end
                [60:69]: begin
                    rx = t_comp'($urandom_range(8) - 4);
                    ry = t_comp'($urandom_range(8) - 4);
                end
                [70:79]: begin
                    // Equal magnitudes must not take the swap reflection.
                    mag = $urandom_range(32768);
                    rx = $urandom_range(1) ? t_comp'(-mag) : t_comp'(mag);
                    ry = $urandom_range(1) ? t_comp'(-mag) : t_comp'(mag);
                end
                [80:87]: begin
                    rx = t_comp'($urandom);
                    ry = '0;
                    if ($urandom_range(1)) begin
                        ry = rx;
                        rx = '0;
                    end
                end
                [88:93]: begin
                    rx = edge_component();
                    ry = edge_component();
                end
                default: begin
                    rx = t_comp'($urandom);
                    ry = t_comp'($urandom_range(15) - 8);
                    if ($urandom_range(1)) begin
                        ry = rx;
                        rx = t_comp'($urandom_range(15) - 8);
                    end
                end
            endcase
            send_vector(rx, ry);
        end
        steady_phase = 1'b0;
        vec_ch.valid <= 1'b0;

        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Result side: random back-pressure, one long hold-off to fill the pipeline.
    initial begin
        hold_off_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_off_done && items_sent >= 150) begin
                hold_off_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (steady_phase) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= 12);
            end
        end
    end

    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((vec_ch.valid && vec_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("simulation failed");
        $finish;
    end

endmodule
